>>> sv/ils_pkg.sv
// Shared constants, codes and controller/datapath handshake types for the indexed list store.
package ils_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int MODE_W  = 3;
  localparam int POS_W   = 16;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 9;

  localparam logic [MODE_W-1:0] MODE_GET      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INS_HEAD = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INS_TAIL = 3'd2;
  localparam logic [MODE_W-1:0] MODE_INS_AT   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DELETE   = 3'd4;

  localparam logic signed [VALUE_W-1:0] BAD_GET_VALUE = -32'sd1;

  typedef enum logic [1:0] {
    RES_ZERO = 2'd0,
    RES_NEG1 = 2'd1,
    RES_MEM  = 2'd2
  } res_sel_t;

  typedef struct packed {
    logic     accept;
    logic     rd_get;
    logic     load_ptr_ins;
    logic     load_ptr_del;
    logic     rd_shift;
    logic     wr_shift;
    logic     put;
    logic     dec_count;
    logic     load_out;
    res_sel_t out_sel;
    logic     out_ok;
  } ils_cmd_t;

  typedef struct packed {
    logic is_get;
    logic get_ok;
    logic ins_ok;
    logic del_ok;
    logic is_ins;
    logic shift_more;
    logic out_free;
  } ils_stat_t;

endpackage

>>> sv/ils_if.sv
// Valid/ready channel interfaces for the request and result words of the list store.
interface ils_req_if;
  logic                                valid;
  logic                                ready;
  logic [ils_pkg::MODE_W-1:0]          mode;
  logic [ils_pkg::POS_W-1:0]           position;
  logic signed [ils_pkg::VALUE_W-1:0]  value;

  modport source (output valid, mode, position, value, input ready);
  modport sink   (input valid, mode, position, value, output ready);
endinterface

interface ils_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [ils_pkg::VALUE_W-1:0]  read_value;
  logic                                done_res;
  logic [ils_pkg::COUNT_W-1:0]         count;

  modport source (output valid, read_value, done_res, count, input ready);
  modport sink   (input valid, read_value, done_res, count, output ready);
endinterface

>>> sv/ils_datapath.sv
// Element memory, length counter, shift pointer and result register of the list store.
module ils_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ils_pkg::ils_cmd_t                   cmd,
  output ils_pkg::ils_stat_t                  stat,
  input  logic [ils_pkg::MODE_W-1:0]          in_mode,
  input  logic [ils_pkg::POS_W-1:0]           in_position,
  input  logic signed [ils_pkg::VALUE_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ils_pkg::VALUE_W-1:0]  out_read_value,
  output logic                                out_done_res,
  output logic [ils_pkg::COUNT_W-1:0]         out_count
);

  logic signed [ils_pkg::VALUE_W-1:0] mem [ils_pkg::CAPACITY];

  logic [ils_pkg::MODE_W-1:0]         mode_r;
  logic [ils_pkg::POS_W-1:0]          pos_r;
  logic signed [ils_pkg::VALUE_W-1:0] val_r;
  logic signed [ils_pkg::VALUE_W-1:0] rdata_r;
  logic [ils_pkg::ADDR_W-1:0]         ptr_r, ptr_nxt;
  logic [ils_pkg::CNT_W-1:0]          count_r, count_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic signed [ils_pkg::VALUE_W-1:0] res_value_r;
  logic                               res_ok_r;
  logic [ils_pkg::CNT_W-1:0]          res_count_r;

  logic [ils_pkg::POS_W-1:0]          cnt_wide;
  logic [ils_pkg::CNT_W-1:0]          pos_eff;
  logic                               is_get, is_ins, is_del, full;
  logic                               ins_more, del_more;
  logic                               rd_en, wr_en;
  logic [ils_pkg::ADDR_W-1:0]         rd_addr;
  logic signed [ils_pkg::VALUE_W-1:0] wr_data;
  logic signed [ils_pkg::VALUE_W-1:0] res_value_sel;

  assign cnt_wide = ils_pkg::POS_W'(count_r);
  assign is_get   = (mode_r == ils_pkg::MODE_GET);
  assign is_ins   = (mode_r inside {ils_pkg::MODE_INS_HEAD, ils_pkg::MODE_INS_TAIL,
                                    ils_pkg::MODE_INS_AT});
  assign is_del   = (mode_r == ils_pkg::MODE_DELETE);
  assign full     = (count_r == ils_pkg::CNT_W'(ils_pkg::CAPACITY));

  // Slot the new word lands in; only meaningful for an insert that is in range.
  always_comb begin
    case (mode_r)
      ils_pkg::MODE_INS_HEAD: pos_eff = '0;
      ils_pkg::MODE_INS_TAIL: pos_eff = count_r;
      default:                pos_eff = ils_pkg::CNT_W'(pos_r);
    endcase
  end

  // An insert walks the pointer down from the tail, a delete walks it up from the hole.
  assign ins_more = (ils_pkg::CNT_W'(ptr_r) > pos_eff);
  assign del_more = ((ils_pkg::CNT_W'(ptr_r) + ils_pkg::CNT_W'(1)) < count_r);

  always_comb begin
    stat.is_get     = is_get;
    stat.get_ok     = is_get && (pos_r < cnt_wide);
    stat.ins_ok     = is_ins && !full && ((mode_r != ils_pkg::MODE_INS_AT) ||
                                          (pos_r <= cnt_wide));
    stat.del_ok     = is_del && (pos_r < cnt_wide);
    stat.is_ins     = is_ins;
    stat.shift_more = is_ins ? ins_more : del_more;
    stat.out_free   = !out_valid_r || out_ready;
  end

  assign rd_en   = cmd.rd_get || cmd.rd_shift;
  assign rd_addr = cmd.rd_get ? ils_pkg::ADDR_W'(pos_r) :
                   (is_ins ? ptr_r - ils_pkg::ADDR_W'(1) : ptr_r + ils_pkg::ADDR_W'(1));
  assign wr_en   = cmd.wr_shift || cmd.put;
  assign wr_data = cmd.put ? val_r : rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ptr_r] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r <= in_mode;
      pos_r  <= in_position;
      val_r  <= in_value;
    end
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.load_ptr_ins) begin
      ptr_nxt = ils_pkg::ADDR_W'(count_r);
    end else if (cmd.load_ptr_del) begin
      ptr_nxt = ils_pkg::ADDR_W'(pos_r);
    end else if (cmd.wr_shift) begin
      ptr_nxt = is_ins ? ptr_r - ils_pkg::ADDR_W'(1) : ptr_r + ils_pkg::ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.put) begin
      count_nxt = count_r + ils_pkg::CNT_W'(1);
    end else if (cmd.dec_count) begin
      count_nxt = count_r - ils_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    case (cmd.out_sel)
      ils_pkg::RES_MEM:  res_value_sel = rdata_r;
      ils_pkg::RES_NEG1: res_value_sel = ils_pkg::BAD_GET_VALUE;
      default:           res_value_sel = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res_value_r <= res_value_sel;
      res_ok_r    <= cmd.out_ok;
      res_count_r <= count_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = res_value_r;
  assign out_done_res   = res_ok_r;
  assign out_count      = ils_pkg::COUNT_W'(res_count_r);

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ils_pkg::CNT_W'(ils_pkg::CAPACITY))
    else $error("element count exceeds capacity");

  a_put_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.put |-> !full)
    else $error("insert written into a full store");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result register loaded over a pending word");

  a_count_steady: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(cmd.put) && !$past(cmd.dec_count)) |-> $stable(count_r))
    else $error("element count moved without an insert or delete");

  a_ins_read_low: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_shift && is_ins) |-> (ptr_r != '0))
    else $error("insert shift read below the first slot");
`endif

endmodule

>>> sv/ils_ctrl.sv
// Sequencing state machine for requests, element shifts and result hand-off of the list store.
module ils_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ils_pkg::ils_stat_t stat,
  output ils_pkg::ils_cmd_t  cmd
);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_DECODE   = 6'b000010,
    ST_GET_WAIT = 6'b000100,
    ST_SHIFT    = 6'b001000,
    ST_SH_WR    = 6'b010000,
    ST_DONE     = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  ils_pkg::res_sel_t sel_r, sel_nxt;
  logic              ok_r, ok_nxt;

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    ok_nxt    = ok_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat.is_get) begin
          if (stat.get_ok) begin
            cmd.rd_get = 1'b1;
            sel_nxt    = ils_pkg::RES_MEM;
            ok_nxt     = 1'b1;
            state_nxt  = ST_GET_WAIT;
          end else begin
            sel_nxt   = ils_pkg::RES_NEG1;
            ok_nxt    = 1'b0;
            state_nxt = ST_DONE;
          end
        end else if (stat.ins_ok) begin
          cmd.load_ptr_ins = 1'b1;
          sel_nxt          = ils_pkg::RES_ZERO;
          ok_nxt           = 1'b1;
          state_nxt        = ST_SHIFT;
        end else if (stat.del_ok) begin
          cmd.load_ptr_del = 1'b1;
          sel_nxt          = ils_pkg::RES_ZERO;
          ok_nxt           = 1'b1;
          state_nxt        = ST_SHIFT;
        end else begin
          // Refused inserts, out-of-range deletes and unknown modes leave the store alone.
          sel_nxt   = ils_pkg::RES_ZERO;
          ok_nxt    = 1'b0;
          state_nxt = ST_DONE;
        end
      end
      ST_GET_WAIT: begin
        state_nxt = ST_DONE;
      end
      ST_SHIFT: begin
        if (stat.shift_more) begin
          cmd.rd_shift = 1'b1;
          state_nxt    = ST_SH_WR;
        end else begin
          if (stat.is_ins) begin
            cmd.put = 1'b1;
          end else begin
            cmd.dec_count = 1'b1;
          end
          state_nxt = ST_DONE;
        end
      end
      ST_SH_WR: begin
        cmd.wr_shift = 1'b1;
        state_nxt    = ST_SHIFT;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    cmd.out_sel = sel_r;
    cmd.out_ok  = ok_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r <= sel_nxt;
    ok_r  <= ok_nxt;
  end

endmodule

>>> sv/indexed_list_store.sv
// Top level of the indexed list store: request and result channels around controller and datapath.
//
// Usage: each request word on in_ch carries mode, position and value; every request yields
// exactly one result word on out_ch with read_value, done_res and the length after the request.
// Both channels move a word at a clock edge where valid and ready are both high.
// The block takes one request at a time; in_ch.ready is high only while no request is in work.
// Work per request: a refused or out-of-range request, an unknown mode or an invalid get goes
// straight to the result; a valid get makes one registered read of the element memory; an insert
// moves the length - slot elements from the slot up, a delete moves the length - 1 - position
// elements above the position down, each with one read and then one write of the element memory.
// The next request is accepted in the idle state that follows the registering of its predecessor's
// result, so a request may enter while the previous result still waits in the output register.
// If the receiver stalls, the result holds in the output register and a following request is
// carried through its shifts, then waits until that register frees up.
// Synchronous active-low reset empties the list and drops any pending result; the element
// memory is not cleared, because only slots below the length are ever read.
module indexed_list_store (
  input  logic      clk,
  input  logic      rst_n,
  ils_req_if.sink   in_ch,
  ils_res_if.source out_ch
);

  ils_pkg::ils_cmd_t  cmd;
  ils_pkg::ils_stat_t stat;

  ils_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ils_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_mode        (in_ch.mode),
    .in_position    (in_ch.position),
    .in_value       (in_ch.value),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_read_value (out_ch.read_value),
    .out_done_res   (out_ch.done_res),
    .out_count      (out_ch.count)
  );

endmodule

>>> test/tb_top.sv
// Testbench for the indexed list store: directed table, then random traffic against a list model.
`timescale 1ns / 100ps

module tb_top;
  import ils_pkg::*;

  localparam int N_DIRECTED    = 24;
  localparam int ITEM_GOAL     = 900;
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int SETTLE_CYCLES = 2 * CAPACITY + 8;
  localparam int IDLE_PCT      = 23;

  // Modes the block has no operation for.
  localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

  localparam bit TYPED     = 1'b1;
  localparam bit PREDICTED = 1'b0;

  typedef struct packed {
    logic [MODE_W-1:0]          mode;
    logic [POS_W-1:0]           position;
    logic signed [VALUE_W-1:0]  value;
  } list_req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  read_value;
    logic                       done_res;
    logic [COUNT_W-1:0]         count;
  } list_reply_t;

  typedef struct packed {
    list_req_t   req;
    logic        typed;
    list_reply_t reply;
  } stim_row_t;

  localparam list_reply_t NO_REPLY = '{32'sd0, 1'b0, 9'd0};

  logic clk = 1'b0;
  logic rst_n;

  ils_req_if req_ch ();
  ils_res_if res_ch ();

  indexed_list_store dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (res_ch)
  );

  always #1 clk = ~clk;

  logic signed [VALUE_W-1:0] shadow_list[$];
  list_reply_t               replies_due[$];
  list_reply_t               oldest_due;
  stim_row_t                 directed_rows [N_DIRECTED];
  int unsigned               mismatch_count = 0;
  int unsigned               cycle_count = 0;
  int unsigned               items_sent = 0;
  bit                        steady_traffic = 1'b0;

  function automatic void log_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic logic put_value(int slot, logic signed [VALUE_W-1:0] v);
    if (shadow_list.size() >= CAPACITY || slot > shadow_list.size()) return 1'b0;
    shadow_list.insert(slot, v);
    return 1'b1;
  endfunction

  // Applies one request to the list model and returns the word the block must answer with.
  function automatic list_reply_t apply_request(list_req_t req);
    list_reply_t r;
    int          pos;
    r = NO_REPLY;
    pos = int'(req.position);
    case (req.mode)
      MODE_GET: begin
        if (pos < shadow_list.size()) begin
          r.read_value = shadow_list[pos];
          r.done_res = 1'b1;
        end else begin
          r.read_value = BAD_GET_VALUE;
        end
      end
      MODE_INS_HEAD: r.done_res = put_value(0, req.value);
      MODE_INS_TAIL: r.done_res = put_value(shadow_list.size(), req.value);
      MODE_INS_AT:   r.done_res = put_value(pos, req.value);
      MODE_DELETE: begin
        if (pos < shadow_list.size()) begin
          shadow_list.delete(pos);
          r.done_res = 1'b1;
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(shadow_list.size());
    return r;
  endfunction

  // Mostly in-range positions, so the list grows and shrinks; grow_pct sets the share of inserts.
  function automatic list_req_t random_request(int grow_pct);
    list_req_t   req;
    int          n;
    int unsigned roll;
    n = shadow_list.size();
    roll = $urandom_range(99);
    case ($urandom_range(9))
      0:       req.value = 32'sh8000_0000;
      1:       req.value = 32'sh7FFF_FFFF;
      2:       req.value = -32'sd1;
      3:       req.value = 32'sd0;
      default: req.value = $urandom;
    endcase
    if ($urandom_range(9) == 0) req.position = POS_W'($urandom);
    else                        req.position = POS_W'($urandom_range(n));
    if ($urandom_range(99) < 4) begin
      req.mode = MODE_W'($urandom_range(MODE_SPARE_7, MODE_SPARE_5));
    end else if (roll < grow_pct) begin
      case ($urandom_range(2))
        0:       req.mode = MODE_INS_HEAD;
        1:       req.mode = MODE_INS_TAIL;
        default: req.mode = MODE_INS_AT;
      endcase
    end else if ($urandom_range(1) == 0) begin
      req.mode = MODE_DELETE;
    end else begin
      req.mode = MODE_GET;
    end
    return req;
  endfunction

  // Drives one request word and returns once it has been taken; valid stays high afterwards.
  task automatic send_request(input list_req_t req, input logic typed,
                              input list_reply_t typed_reply);
    list_reply_t predicted;
    bit          taken;
    while (!steady_traffic && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.mode     <= req.mode;
    req_ch.position <= req.position;
    req_ch.value    <= req.value;
    // Ready is sampled between edges, where it holds its value for the coming edge.
    do begin
      @(negedge clk);
      taken = req_ch.ready;
      @(posedge clk);
    end while (!taken);
    predicted = apply_request(req);
    replies_due.push_back(typed ? typed_reply : predicted);
    items_sent++;
  endtask

  task automatic wait_for_replies();
    req_ch.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    res_ch.ready <= steady_traffic || ($urandom_range(99) >= IDLE_PCT);
  end

  // A result word is taken at the next rising edge when valid and ready are both high here.
  always @(negedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (replies_due.size() == 0) begin
        log_mismatch($sformatf("result word with none expected: read_value %h done_res %b count %0d",
                               res_ch.read_value, res_ch.done_res, res_ch.count));
      end else begin
        oldest_due = replies_due.pop_front();
        if (res_ch.read_value !== oldest_due.read_value)
          log_mismatch($sformatf("read_value expected %h, got %h",
                                 oldest_due.read_value, res_ch.read_value));
        if (res_ch.done_res !== oldest_due.done_res)
          log_mismatch($sformatf("done_res expected %b, got %b",
                                 oldest_due.done_res, res_ch.done_res));
        if (res_ch.count !== oldest_due.count)
          log_mismatch($sformatf("count expected %0d, got %0d",
                                 oldest_due.count, res_ch.count));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    list_req_t req;
    int        mixed_items;
    int        k;

    rst_n           = 1'b0;
    req_ch.valid    = 1'b0;
    req_ch.mode     = MODE_GET;
    req_ch.position = '0;
    req_ch.value    = '0;
    res_ch.ready    = 1'b0;

    directed_rows = '{
      '{'{MODE_GET,      16'h0000, 32'sh0000_0000}, TYPED, '{BAD_GET_VALUE, 1'b0, 9'd0}},
      '{'{MODE_DELETE,   16'h0000, 32'sh0000_0000}, TYPED, '{32'sd0, 1'b0, 9'd0}},
      '{'{MODE_INS_AT,   16'h0001, 32'sh0000_0011}, TYPED, '{32'sd0, 1'b0, 9'd0}},
      '{'{MODE_INS_AT,   16'h0000, 32'sh7FFF_FFFF}, TYPED, '{32'sd0, 1'b1, 9'd1}},
      '{'{MODE_INS_HEAD, 16'hFFFF, 32'sh8000_0000}, TYPED, '{32'sd0, 1'b1, 9'd2}},
      '{'{MODE_INS_TAIL, 16'h8000, 32'shFFFF_FFFF}, TYPED, '{32'sd0, 1'b1, 9'd3}},
      '{'{MODE_INS_AT,   16'h0003, 32'sh5A5A_5A5A}, TYPED, '{32'sd0, 1'b1, 9'd4}},
      '{'{MODE_GET,      16'h0000, 32'shFFFF_FFFF}, TYPED, '{32'sh8000_0000, 1'b1, 9'd4}},
      '{'{MODE_GET,      16'h0001, 32'sh0000_0000}, TYPED, '{32'sh7FFF_FFFF, 1'b1, 9'd4}},
      '{'{MODE_GET,      16'h0003, 32'sh0000_0000}, TYPED, '{32'sh5A5A_5A5A, 1'b1, 9'd4}},
      '{'{MODE_GET,      16'h0004, 32'sh0000_0000}, TYPED, '{BAD_GET_VALUE, 1'b0, 9'd4}},
      '{'{MODE_GET,      16'hFFFF, 32'sh0000_0000}, TYPED, '{BAD_GET_VALUE, 1'b0, 9'd4}},
      '{'{MODE_SPARE_5,  16'h0002, 32'sh0000_1234}, TYPED, '{32'sd0, 1'b0, 9'd4}},
      '{'{MODE_SPARE_6,  16'hFFFF, 32'shFFFF_FFFF}, TYPED, '{32'sd0, 1'b0, 9'd4}},
      '{'{MODE_SPARE_7,  16'h0000, 32'sh8000_0000}, TYPED, '{32'sd0, 1'b0, 9'd4}},
      '{'{MODE_INS_AT,   16'hFFFF, 32'sh0000_0000}, TYPED, '{32'sd0, 1'b0, 9'd4}},
      '{'{MODE_INS_AT,   16'h0002, 32'sh1234_5678}, PREDICTED, NO_REPLY},
      '{'{MODE_GET,      16'h0002, 32'sh0000_0000}, PREDICTED, NO_REPLY},
      '{'{MODE_DELETE,   16'hFFFF, 32'sh0000_0000}, TYPED, '{32'sd0, 1'b0, 9'd5}},
      '{'{MODE_DELETE,   16'h0004, 32'sh7FFF_FFFF}, PREDICTED, NO_REPLY},
      '{'{MODE_DELETE,   16'h0000, 32'sh0000_0000}, PREDICTED, NO_REPLY},
      '{'{MODE_GET,      16'h0000, 32'sh0000_0000}, PREDICTED, NO_REPLY},
      '{'{MODE_GET,      16'h0002, 32'sh0000_0000}, PREDICTED, NO_REPLY},
      '{'{MODE_INS_HEAD, 16'h0000, 32'sh0000_0000}, PREDICTED, NO_REPLY}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < N_DIRECTED; k++)
      send_request(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].reply);
    wait_for_replies();

    // Fill the store to capacity, then hit it with inserts of every kind while full.
    while (shadow_list.size() < CAPACITY) begin
      send_request(random_request(85), PREDICTED, NO_REPLY);
    end
    for (k = MODE_INS_HEAD; k <= MODE_INS_AT; k++) begin
      req = random_request(100);
      req.mode = MODE_W'(k);
      send_request(req, PREDICTED, NO_REPLY);
    end
    repeat (25) begin
      send_request(random_request(50), PREDICTED, NO_REPLY);
    end
    wait_for_replies();

    // Drain to a short list; reads turn into deletes here so the list shrinks quickly.
    while (shadow_list.size() > 4) begin
      req = random_request(0);
      if (req.mode == MODE_GET) req.mode = MODE_DELETE;
      send_request(req, PREDICTED, NO_REPLY);
    end

    // Mixed traffic on a short list; the first stretch runs with no idling on either side.
    steady_traffic = 1'b1;
    mixed_items = 0;
    while (items_sent < ITEM_GOAL || mixed_items < 200) begin
      if (mixed_items == 150) steady_traffic = 1'b0;
      send_request(random_request(35), PREDICTED, NO_REPLY);
      mixed_items++;
    end
    steady_traffic = 1'b0;

    wait_for_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
sv/ils_pkg.sv
sv/ils_if.sv
sv/ils_datapath.sv
sv/ils_ctrl.sv
sv/indexed_list_store.sv
test/tb_top.sv
